// ----- hdl/gbfs_pkg.sv -----
// Shared types and codes for the graph walk engine.
`timescale 1ns / 1ps
package gbfs_pkg;
  localparam logic [1:0] FUNC_EDGE   = 2'd0;
  localparam logic [1:0] FUNC_WALK   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] KIND_VISIT   = 3'd0;
  localparam logic [2:0] KIND_STORED  = 3'd1;
  localparam logic [2:0] KIND_REJECT  = 3'd2;
  localparam logic [2:0] KIND_NOVERT  = 3'd3;
  localparam logic [2:0] KIND_CLEARED = 3'd4;

  localparam int unsigned VERT_W = 6;
  localparam int unsigned CNT_W  = 7;

  // table geometry
  localparam int unsigned NUM_VERT   = 64;
  localparam int unsigned MAX_DEGREE = 16;
  localparam int unsigned DEG_IDX_W  = $clog2(MAX_DEGREE);
  localparam int unsigned DEG_W      = $clog2(MAX_DEGREE + 1);

  // one command passed from the front end to the back end
  typedef struct packed {
    logic [1:0]        func;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
  } cmd_t;
endpackage

// ----- hdl/gbfs_front.sv -----
// Front end: accept items, drop unused codes, and queue commands.
`timescale 1ns / 1ps
module gbfs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic [5:0]          in_vertex_a,
  input  logic [5:0]          in_vertex_b,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output gbfs_pkg::cmd_t      cmd
);
  // two-entry queue
  gbfs_pkg::cmd_t q_r [2];
  logic           rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop, useful;

  assign in_stall  = (cnt_r == 2'd2);
  assign useful    = (in_func != gbfs_pkg::FUNC_UNUSED);
  assign push      = in_valid && !in_stall && useful;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= '{func: in_func, vertex_a: in_vertex_a, vertex_b: in_vertex_b};
    end
  end
endmodule

// ----- hdl/gbfs_back.sv -----
// Back end: edge inserts, clears and the breadth-first walk over the tables.
`timescale 1ns / 1ps
module gbfs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          vertex_count,
  input  logic                cmd_valid,
  output logic                cmd_take,
  input  gbfs_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_kind,
  output logic [5:0]          out_vertex,
  output logic                out_last
);
  localparam int unsigned NV  = gbfs_pkg::NUM_VERT;
  localparam int unsigned DW  = gbfs_pkg::DEG_IDX_W;
  localparam int unsigned DCW = gbfs_pkg::DEG_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE1 = 4'd1;
  localparam logic [3:0] S_EDGE2 = 4'd2;
  localparam logic [3:0] S_VCLR  = 4'd3;
  localparam logic [3:0] S_DEQ   = 4'd4;
  localparam logic [3:0] S_QRD   = 4'd5;
  localparam logic [3:0] S_NRD   = 4'd6;
  localparam logic [3:0] S_NVIS  = 4'd7;
  localparam logic [3:0] S_NCHK  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_DCLR  = 4'd10;

  logic [3:0]     st_r, st_nxt;
  logic [DCW-1:0] deg_mem [NV];
  logic           vis_mem [NV];
  logic [5:0]     nbr_mem [NV*gbfs_pkg::MAX_DEGREE];
  logic [5:0]     wq_mem [NV];
  logic [DCW-1:0] da_r, db_r;
  logic [5:0]     nbr_q_r, wq_q_r;
  logic           vis_q_r;
  logic [6:0]     head_r, tail_r, nv_r;
  logic [5:0]     a_r, b_r, cur_r, clr_r;
  logic [DCW-1:0] idx_r, cdeg_r;

  logic           ov_r;
  logic [2:0]     ok_r;
  logic [5:0]     ovx_r;
  logic           ol_r;
  logic           emit;
  logic [2:0]     ekind;
  logic [5:0]     evx;
  logic           elast;

  logic [6:0]     nv;
  logic           out_free;
  logic           walk_in, edge_ok, scan_done, take_w;

  assign nv        = (vertex_count > 7'd64) ? 7'd64 : vertex_count;
  assign out_free  = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_vertex= ovx_r;
  assign out_last  = ol_r;

  assign walk_in   = {1'b0, cmd.vertex_a} < nv;
  assign edge_ok   = ({1'b0, a_r} < nv) && ({1'b0, b_r} < nv) &&
                     (da_r < DCW'(gbfs_pkg::MAX_DEGREE)) &&
                     (db_r < DCW'(gbfs_pkg::MAX_DEGREE));
  assign scan_done = (idx_r >= cdeg_r);
  assign take_w    = ({1'b0, nbr_q_r} < nv_r) && !vis_q_r && (tail_r < 7'd64);

  always_comb begin
    st_nxt   = st_r;
    cmd_take = 1'b0;
    emit     = 1'b0;
    ekind    = gbfs_pkg::KIND_VISIT;
    evx      = cmd.vertex_a;
    elast    = 1'b1;
    unique case (st_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          unique case (cmd.func)
            gbfs_pkg::FUNC_EDGE: st_nxt = S_EDGE1;
            gbfs_pkg::FUNC_WALK: begin
              if (nv == 7'd0) begin
                emit  = 1'b1;
                ekind = gbfs_pkg::KIND_NOVERT;
              end else if (!walk_in) begin
                emit  = 1'b1;
                ekind = gbfs_pkg::KIND_REJECT;
              end else begin
                st_nxt = S_VCLR;
              end
            end
            gbfs_pkg::FUNC_CLEAR: begin
              emit   = 1'b1;
              ekind  = gbfs_pkg::KIND_CLEARED;
              st_nxt = S_DCLR;
            end
            default: ;
          endcase
        end
      end
      S_EDGE1: begin
        if (out_free) begin
          emit   = 1'b1;
          evx    = a_r;
          ekind  = edge_ok ? gbfs_pkg::KIND_STORED : gbfs_pkg::KIND_REJECT;
          st_nxt = (edge_ok && a_r != b_r) ? S_EDGE2 : S_IDLE;
        end
      end
      S_EDGE2: st_nxt = S_IDLE;
      S_DCLR:  st_nxt = (clr_r == 6'd63) ? S_IDLE : S_DCLR;
      S_VCLR:  st_nxt = (clr_r == 6'd63) ? S_DEQ : S_VCLR;
      S_DEQ:   st_nxt = S_QRD;
      S_QRD:   st_nxt = S_NRD;
      S_NRD:   st_nxt = scan_done ? S_EMIT : S_NVIS;
      S_NVIS:  st_nxt = S_NCHK;
      S_NCHK:  st_nxt = S_NRD;
      S_EMIT: begin
        // neighbors are already queued, so an empty queue marks the last visit
        if (out_free) begin
          emit   = 1'b1;
          ekind  = gbfs_pkg::KIND_VISIT;
          evx    = cur_r;
          elast  = !(head_r < tail_r);
          st_nxt = (head_r < tail_r) ? S_DEQ : S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // control; reset starts a clearing pass over the degree table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_DCLR;
      ov_r   <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      clr_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (st_r == S_VCLR || st_r == S_DCLR) begin
        clr_r <= clr_r + 1'b1;
      end else if (cmd_take) begin
        clr_r <= '0;
      end
      if (cmd_take && cmd.func == gbfs_pkg::FUNC_WALK) begin
        head_r <= '0;
      end else if (st_r == S_QRD) begin
        head_r <= head_r + 1'b1;
      end
      if (cmd_take && cmd.func == gbfs_pkg::FUNC_WALK) begin
        tail_r <= '0;
      end else if (st_r == S_VCLR && clr_r == 6'd63) begin
        tail_r <= 7'd1;
      end else if (st_r == S_NCHK && take_w) begin
        tail_r <= tail_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ok_r  <= ekind;
      ovx_r <= evx;
      ol_r  <= elast;
    end
    if (cmd_take) begin
      a_r  <= cmd.vertex_a;
      b_r  <= cmd.vertex_b;
      nv_r <= nv;
    end
    if (st_r == S_QRD) begin
      cur_r <= wq_q_r;
      idx_r <= '0;
    end else if (st_r == S_NRD && !scan_done) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // degree table: two reads at command take, one per dequeued vertex
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      da_r <= deg_mem[cmd.vertex_a];
      db_r <= deg_mem[cmd.vertex_b];
    end
    if (st_r == S_QRD) begin
      cdeg_r <= deg_mem[wq_q_r];
    end
    if (st_r == S_DCLR) begin
      deg_mem[clr_r] <= '0;
    end else if (st_r == S_EDGE1 && emit && edge_ok) begin
      deg_mem[a_r] <= da_r + 1'b1;
    end else if (st_r == S_EDGE2) begin
      deg_mem[b_r] <= db_r + 1'b1;
    end
  end

  // neighbor table
  always_ff @(posedge clk) begin
    if (st_r == S_EDGE1 && emit && edge_ok) begin
      nbr_mem[{a_r, da_r[DW-1:0]}] <= b_r;
    end else if (st_r == S_EDGE2) begin
      nbr_mem[{b_r, db_r[DW-1:0]}] <= a_r;
    end
    if (st_r == S_NRD && !scan_done) begin
      nbr_q_r <= nbr_mem[{cur_r, idx_r[DW-1:0]}];
    end
  end

  // visited map: cleared one entry per cycle, start vertex marked on its pass
  always_ff @(posedge clk) begin
    if (st_r == S_VCLR) begin
      vis_mem[clr_r] <= (clr_r == a_r);
    end else if (st_r == S_NCHK && take_w) begin
      vis_mem[nbr_q_r] <= 1'b1;
    end
    if (st_r == S_NVIS) begin
      vis_q_r <= vis_mem[nbr_q_r];
    end
  end

  // walk queue
  always_ff @(posedge clk) begin
    if (st_r == S_VCLR && clr_r == 6'd63) begin
      wq_mem[6'd0] <= a_r;
    end else if (st_r == S_NCHK && take_w) begin
      wq_mem[tail_r[5:0]] <= nbr_q_r;
    end
    if (st_r == S_DEQ) begin
      wq_q_r <= wq_mem[head_r[5:0]];
    end
  end
endmodule

// ----- hdl/graph_bfs_engine_core.sv -----
// Top level of the graph walk engine: config register, front end, back end.
`timescale 1ns / 1ps
// Edge insert: the back end takes the command from the queue, registers its
// result, then writes the second list unless self-loop or rejected. Walk:
// the visited map is cleared, then each vertex is dequeued, its neighbors read
// and checked, and it is emitted; clear: a degree-table pass after its result.
// Reset (rst_n low, synchronous) sets vertex_count to 64 and starts a pass
// that empties all lists; items wait in the front queue meanwhile.
module graph_bfs_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_vertex_a,
  input  logic [5:0]  in_vertex_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [5:0]  out_vertex,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [6:0]     vcount_r;
  logic           cmd_valid, cmd_take;
  gbfs_pkg::cmd_t cmd;

  // single register at address 0; transfer completes on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {25'd0, vcount_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      vcount_r <= cfg_pwdata[6:0];
    end
  end

  gbfs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_vertex_a, .in_vertex_b,
    .cmd_valid, .cmd_take, .cmd
  );

  gbfs_back u_back (
    .clk, .rst_n, .vertex_count(vcount_r), .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_kind, .out_vertex, .out_last
  );
endmodule

// ----- test/gbfs_checker.sv -----
// Predicts graph engine results from observed transfers and compares them.
`timescale 1ns / 1ps
module gbfs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_vertex_a,
  input  logic [5:0]  in_vertex_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [5:0]  out_vertex,
  input  logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);
  localparam int MAXV = 64;
  localparam int MAXD = 16;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] vertex;
    logic       last;
  } graph_result_t;

  graph_result_t result_q[$];
  logic [6:0] model_count;
  logic [4:0] model_degree [MAXV];
  logic [5:0] model_table [MAXV*MAXD];

  assign pending = result_q.size();

  function automatic int unsigned usable_count();
    return (model_count > MAXV) ? MAXV : model_count;
  endfunction

  task automatic push_result(logic [2:0] k, logic [5:0] v, logic l);
    graph_result_t r;
    r.kind = k; r.vertex = v; r.last = l;
    result_q.push_back(r);
  endtask

  task automatic predict_edge(logic [5:0] a, logic [5:0] b);
    int unsigned nv;
    bit ok;
    nv = usable_count();
    ok = (a < nv) && (b < nv);
    if (ok && (model_degree[a] >= MAXD || model_degree[b] >= MAXD)) ok = 0;
    if (ok) begin
      model_table[a*MAXD + model_degree[a]] = b;
      model_degree[a]++;
      if (a != b) begin
        model_table[b*MAXD + model_degree[b]] = a;
        model_degree[b]++;
      end
    end
    push_result(ok ? gbfs_pkg::KIND_STORED : gbfs_pkg::KIND_REJECT, a, 1'b1);
  endtask

  task automatic predict_walk(logic [5:0] start);
    int unsigned nv, head, tail, w;
    bit seen [MAXV];
    logic [5:0] order [MAXV];
    nv = usable_count();
    if (nv == 0) begin
      push_result(gbfs_pkg::KIND_NOVERT, start, 1'b1);
      return;
    end
    if (start >= nv) begin
      push_result(gbfs_pkg::KIND_REJECT, start, 1'b1);
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    head = 0; tail = 1;
    order[0] = start;
    seen[start] = 1;
    while (head < tail) begin
      for (int i = 0; i < model_degree[order[head]]; i++) begin
        w = model_table[order[head]*MAXD + i];
        if (w < nv && !seen[w] && tail < MAXV) begin
          seen[w] = 1;
          order[tail] = w;
          tail++;
        end
      end
      head++;
      push_result(gbfs_pkg::KIND_VISIT, order[head-1], head == tail);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("checker: %s mismatch got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    graph_result_t want;
    if (!rst_n) begin
      model_count <= 7'd64;
      foreach (model_degree[i]) model_degree[i] = '0;
      result_q.delete();
      fail_count = 0;
    end else begin
      // compare the result first; prediction of this edge's transfer cannot
      // produce a result in the same cycle
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result kind", out_kind, -1);
        end else begin
          want = result_q.pop_front();
          if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
          if (out_vertex !== want.vertex) report_mismatch("vertex", out_vertex, want.vertex);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
      if (in_valid && !in_stall) begin
        case (in_func)
          gbfs_pkg::FUNC_EDGE:  predict_edge(in_vertex_a, in_vertex_b);
          gbfs_pkg::FUNC_WALK:  predict_walk(in_vertex_a);
          gbfs_pkg::FUNC_CLEAR: begin
            foreach (model_degree[i]) model_degree[i] = '0;
            push_result(gbfs_pkg::KIND_CLEARED, in_vertex_a, 1'b1);
          end
          default: ;
        endcase
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        model_count <= cfg_pwdata[6:0];
    end
  end
endmodule

// ----- test/tb.sv -----
// Stimulus and verdict for the graph walk engine.
`timescale 1ns / 1ps
module tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [5:0]  in_vertex_a = '0;
  logic [5:0]  in_vertex_b = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  out_kind;
  logic [5:0]  out_vertex;
  logic        out_last;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  bit          hold_off = 0;
  logic [6:0]  cur_count = 7'd64;

  always #2 clk = ~clk;

  graph_bfs_engine_core dut (.*);
  gbfs_checker chk (.*);

  // Receiver: random stall pattern and one long hold-off requested by the
  // stimulus to back the block up.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      n = $urandom_range(0, 3);
      case (n)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= ($urandom_range(0, 4) == 0);
        default: out_stall <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  // Write one register over the config port: setup cycle, then access cycle.
  task automatic write_reg(logic [1:0] addr, logic [31:0] value);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // Offer one command and hold it until it transfers.
  task automatic send_cmd(logic [1:0] f, logic [5:0] a, logic [5:0] b);
    in_valid <= 1; in_func <= f; in_vertex_a <= a; in_vertex_b <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid for a random gap after some bursts.
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Let all expected results arrive, then allow the walk tail to settle.
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_count(logic [6:0] c);
    drain();
    write_reg(2'd0, {25'd0, c});
    cur_count = c;
  endtask

  // Random vertex, mostly in range of the current vertex count.
  function automatic logic [5:0] pick_vertex();
    if (cur_count != 7'd0 && $urandom_range(0, 9) != 0)
      return 6'($urandom_range(0, (cur_count > 7'd64 ? 32'd64 : 32'(cur_count)) - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic random_phase(int items);
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_cmd(gbfs_pkg::FUNC_EDGE, pick_vertex(), pick_vertex());
      else if (r < 90)
        send_cmd(gbfs_pkg::FUNC_WALK, pick_vertex(), 6'($urandom_range(0, 63)));
      else if (r < 95)
        send_cmd(gbfs_pkg::FUNC_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      else
        send_cmd(gbfs_pkg::FUNC_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      maybe_gap();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    repeat (70) @(negedge clk);

    // directed: extremes, self-loop, full list, walks, clear, unused code
    send_cmd(gbfs_pkg::FUNC_EDGE, 6'd0, 6'd63);
    send_cmd(gbfs_pkg::FUNC_EDGE, 6'd5, 6'd5);
    for (int i = 1; i <= 16; i++) send_cmd(gbfs_pkg::FUNC_EDGE, 6'd7, 6'(i + 20));
    send_cmd(gbfs_pkg::FUNC_WALK, 6'd0, 6'd0);
    send_cmd(gbfs_pkg::FUNC_WALK, 6'd7, 6'd63);
    send_cmd(gbfs_pkg::FUNC_UNUSED, 6'd63, 6'd63);
    send_cmd(gbfs_pkg::FUNC_CLEAR, 6'd42, 6'd21);
    send_cmd(gbfs_pkg::FUNC_WALK, 6'd63, 6'd0);

    // no vertices: walk and edge with count zero
    set_count(7'd0);
    send_cmd(gbfs_pkg::FUNC_WALK, 6'd3, 6'd0);
    send_cmd(gbfs_pkg::FUNC_EDGE, 6'd0, 6'd0);

    // small graph, then lower the count to leave stale neighbors
    set_count(7'd10);
    random_phase(50);
    set_count(7'd4);
    send_cmd(gbfs_pkg::FUNC_WALK, 6'd5, 6'd0);
    random_phase(20);

    // above the vertex limit: acts as the full set
    set_count(7'd127);
    random_phase(40);
    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    random_phase(40);
    set_count(7'd64);
    random_phase(34);
    drain();

    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/gbfs_pkg.sv
hdl/gbfs_front.sv
hdl/gbfs_back.sv
hdl/graph_bfs_engine_core.sv
test/gbfs_checker.sv
test/tb.sv
